// ----- rtl/otl_pkg.sv -----
// shared types and constants of the ordered task list
// used by otl_cell and ordered_task_list; no dependencies
package otl_pkg;

  localparam int unsigned SLOTS    = 8;
  localparam int unsigned TAG_BITS = 8;
  localparam int unsigned KEY_BITS = 16;
  localparam int unsigned SLOT_W   = $clog2(SLOTS);
  localparam int unsigned CNT_W    = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    REQ_INSERT   = 2'd0,
    REQ_REMOVE   = 2'd1,
    REQ_RETAG    = 2'd2,
    REQ_DISPATCH = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_POOL_FULL  = 2'd1,
    ST_NOT_LISTED = 2'd2,
    ST_EMPTY      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_RETAG,
    CELL_ROTATE
  } cell_op_e;

  typedef struct packed {
    req_e                       req_type;
    logic signed [KEY_BITS-1:0] order_key;
    logic [TAG_BITS-1:0]        task_tag;
    logic [SLOT_W-1:0]          target_slot;
  } in_item_t;

  typedef struct packed {
    status_e                    status;
    logic [SLOT_W-1:0]          slot_out;
    logic [TAG_BITS-1:0]        tag_out;
    logic signed [KEY_BITS-1:0] key_out;
    logic [CNT_W-1:0]           position;
    logic                       last;
  } out_item_t;

  typedef struct packed {
    logic                       valid;
    logic [SLOT_W-1:0]          slot;
    logic [TAG_BITS-1:0]        tag;
    logic signed [KEY_BITS-1:0] key;
  } entry_t;

  typedef struct packed {
    cell_op_e                   op;
    logic [SLOT_W-1:0]          new_slot;
    logic [TAG_BITS-1:0]        new_tag;
    logic signed [KEY_BITS-1:0] new_key;
    logic [SLOT_W-1:0]          tgt_slot;
  } cell_ctl_t;

endpackage

// ----- rtl/otl_cell.sv -----
// one cell of the sorted run list: holds one entry and trades it with its neighbors
// depends on otl_pkg
module otl_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  otl_pkg::cell_ctl_t ctl_i,
  input  otl_pkg::entry_t   left_i,
  input  otl_pkg::entry_t   right_i,
  input  logic              left_gt_i,
  input  logic              left_hit_i,
  output otl_pkg::entry_t   ent_o,
  output logic              gt_o,
  output logic              hit_o,
  output logic              self_hit_o
);

  logic            valid_q, valid_d;
  otl_pkg::entry_t data_q, data_d;
  otl_pkg::entry_t new_ent;

  always_comb begin
    ent_o       = data_q;
    ent_o.valid = valid_q;
  end

  // empty cells count as greater so a new entry lands in the first free cell
  assign gt_o       = !valid_q || ($signed(data_q.key) > $signed(ctl_i.new_key));
  assign self_hit_o = valid_q && (data_q.slot == ctl_i.tgt_slot);
  assign hit_o      = left_hit_i || self_hit_o;

  always_comb begin
    new_ent.valid = 1'b1;
    new_ent.slot  = ctl_i.new_slot;
    new_ent.tag   = ctl_i.new_tag;
    new_ent.key   = ctl_i.new_key;
  end

  always_comb begin
    data_d  = ent_o;
    case (ctl_i.op)
      otl_pkg::CELL_INSERT: begin
        if (gt_o) begin
          data_d = left_gt_i ? left_i : new_ent;
        end
      end
      otl_pkg::CELL_REMOVE: begin
        if (hit_o) begin
          data_d = right_i;
        end
      end
      otl_pkg::CELL_RETAG: begin
        if (self_hit_o) begin
          data_d.tag = ctl_i.new_tag;
        end
      end
      otl_pkg::CELL_ROTATE: begin
        data_d = right_i;
      end
      default: begin
        data_d = ent_o;
      end
    endcase
    valid_d = data_d.valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

// ----- rtl/ordered_task_list.sv -----
// ordered task list: run list kept sorted in a chain of otl_cell, plus a free-slot fifo
// insert, remove, retag: one result each; the request is registered, then the result is registered in S_EXEC
// dispatch: one result per listed entry (ST_EMPTY if none), SLOTS rotation steps through the cell chain
// a new request is taken only after the previous one is finished; output stalls delay completion
// reset empties the run list and refills the free fifo with slots in order, no clearing pass
// depends on otl_pkg and otl_cell
module ordered_task_list (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  otl_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output otl_pkg::out_item_t out_data_o
);

  localparam int unsigned SLOTS  = otl_pkg::SLOTS;
  localparam int unsigned SLOT_W = otl_pkg::SLOT_W;
  localparam int unsigned CNT_W  = otl_pkg::CNT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK
  } state_e;

  state_e             state_q, state_d;
  otl_pkg::in_item_t  req_q;
  otl_pkg::out_item_t out_q, out_d;
  logic               out_vld_q, out_vld_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [SLOT_W-1:0]  head_q, head_d, tail_q, tail_d;
  logic [SLOT_W-1:0]  wk_q, wk_d;
  logic [SLOT_W-1:0]  fq_q [SLOTS];
  logic               fq_we;

  otl_pkg::cell_ctl_t ctl;
  otl_pkg::entry_t    ent [SLOTS];
  otl_pkg::entry_t    last_right;
  otl_pkg::entry_t    hit_ent;
  logic [SLOTS-1:0]   gt, hit, self_hit;
  logic               go, full, found;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign go    = !out_vld_q || !out_stall_i;
  assign full  = (cnt_q == CNT_W'(SLOTS));
  assign found = hit[SLOTS-1];

  // the chain wraps around only while a dispatch rotates it
  assign last_right = (ctl.op == otl_pkg::CELL_ROTATE) ? ent[0] : '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    otl_pkg::entry_t left_w, right_w;
    logic            lgt_w, lhit_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
      assign lgt_w  = 1'b0;
      assign lhit_w = 1'b0;
    end else begin : g_rest
      assign left_w = ent[i-1];
      assign lgt_w  = gt[i-1];
      assign lhit_w = hit[i-1];
    end
    if (i == SLOTS - 1) begin : g_last
      assign right_w = last_right;
    end else begin : g_mid
      assign right_w = ent[i+1];
    end
    otl_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .left_i     (left_w),
      .right_i    (right_w),
      .left_gt_i  (lgt_w),
      .left_hit_i (lhit_w),
      .ent_o      (ent[i]),
      .gt_o       (gt[i]),
      .hit_o      (hit[i]),
      .self_hit_o (self_hit[i])
    );
  end

  // entry of the target slot, at most one cell matches
  always_comb begin
    hit_ent = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (self_hit[i]) begin
        hit_ent = hit_ent | ent[i];
      end
    end
  end

  function automatic logic [SLOT_W-1:0] ptr_inc(input logic [SLOT_W-1:0] p);
    ptr_inc = (p == SLOT_W'(SLOTS - 1)) ? '0 : p + SLOT_W'(1);
  endfunction

  always_comb begin
    state_d      = state_q;
    out_d        = out_q;
    out_vld_d    = out_vld_q;
    cnt_d        = cnt_q;
    head_d       = head_q;
    tail_d       = tail_q;
    wk_d         = wk_q;
    fq_we        = 1'b0;
    ctl.op       = otl_pkg::CELL_HOLD;
    ctl.new_slot = fq_q[head_q];
    ctl.new_tag  = req_q.task_tag;
    ctl.new_key  = req_q.order_key;
    ctl.tgt_slot = req_q.target_slot;

    if (go) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (go) begin
          out_vld_d      = 1'b1;
          out_d.status   = otl_pkg::ST_OK;
          out_d.slot_out = req_q.target_slot;
          out_d.tag_out  = '0;
          out_d.key_out  = '0;
          out_d.position = cnt_q;
          out_d.last     = 1'b1;
          state_d        = S_IDLE;
          case (req_q.req_type)
            otl_pkg::REQ_INSERT: begin
              if (full) begin
                out_d.status   = otl_pkg::ST_POOL_FULL;
                out_d.slot_out = '0;
              end else begin
                ctl.op         = otl_pkg::CELL_INSERT;
                out_d.slot_out = fq_q[head_q];
                out_d.tag_out  = req_q.task_tag;
                out_d.key_out  = req_q.order_key;
                out_d.position = cnt_q + CNT_W'(1);
                cnt_d          = cnt_q + CNT_W'(1);
                head_d         = ptr_inc(head_q);
              end
            end
            otl_pkg::REQ_REMOVE: begin
              if (!found) begin
                out_d.status = otl_pkg::ST_NOT_LISTED;
              end else begin
                ctl.op         = otl_pkg::CELL_REMOVE;
                out_d.tag_out  = hit_ent.tag;
                out_d.key_out  = hit_ent.key;
                out_d.position = cnt_q - CNT_W'(1);
                cnt_d          = cnt_q - CNT_W'(1);
                fq_we          = 1'b1;
                tail_d         = ptr_inc(tail_q);
              end
            end
            otl_pkg::REQ_RETAG: begin
              if (!found) begin
                out_d.status = otl_pkg::ST_NOT_LISTED;
              end else begin
                ctl.op        = otl_pkg::CELL_RETAG;
                out_d.tag_out = req_q.task_tag;
                out_d.key_out = hit_ent.key;
              end
            end
            otl_pkg::REQ_DISPATCH: begin
              if (cnt_q == '0) begin
                out_d.status   = otl_pkg::ST_EMPTY;
                out_d.slot_out = '0;
              end else begin
                out_vld_d = 1'b0;
                wk_d      = '0;
                state_d   = S_WALK;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_WALK: begin
        if (go) begin
          ctl.op = otl_pkg::CELL_ROTATE;
          // full turn of the chain restores the order, only listed entries are reported
          if (CNT_W'(wk_q) < cnt_q) begin
            out_vld_d      = 1'b1;
            out_d.status   = otl_pkg::ST_OK;
            out_d.slot_out = ent[0].slot;
            out_d.tag_out  = ent[0].tag;
            out_d.key_out  = ent[0].key;
            out_d.position = CNT_W'(wk_q) + CNT_W'(1);
            out_d.last     = ((CNT_W'(wk_q) + CNT_W'(1)) == cnt_q);
          end
          wk_d = wk_q + SLOT_W'(1);
          if (wk_q == SLOT_W'(SLOTS - 1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_q     <= '0;
      out_vld_q <= 1'b0;
      cnt_q     <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      wk_q      <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        fq_q[i] <= SLOT_W'(i);
      end
    end else begin
      state_q   <= state_d;
      out_q     <= out_d;
      out_vld_q <= out_vld_d;
      cnt_q     <= cnt_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      wk_q      <= wk_d;
      if (fq_we) begin
        fq_q[tail_q] <= req_q.target_slot;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      req_q <= in_data_i;
    end
  end

endmodule

// ----- dv/tb.sv -----
// testbench for ordered_task_list: directed and random requests, result checking
// through a sorted-list predictor kept in a small scoreboard class; depends on otl_pkg
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DIRECTED_ITEMS = 90;
  localparam int unsigned QUIET_LIMIT    = 2000;
  localparam int unsigned DRAIN_CYCLES   = 30;

  class task_list_board;
    otl_pkg::out_item_t                  expected_q[$];
    int unsigned                         run_order[$];
    int unsigned                         free_fifo[$];
    logic [otl_pkg::TAG_BITS-1:0]        tag_of[otl_pkg::SLOTS];
    logic signed [otl_pkg::KEY_BITS-1:0] key_of[otl_pkg::SLOTS];
    int                                  errors;

    function new();
      errors = 0;
      for (int s = 0; s < otl_pkg::SLOTS; s++) free_fifo.push_back(s);
    endfunction

    function void queue_result(otl_pkg::status_e st, logic [otl_pkg::SLOT_W-1:0] slot,
                               logic [otl_pkg::TAG_BITS-1:0] tag,
                               logic signed [otl_pkg::KEY_BITS-1:0] key,
                               logic [otl_pkg::CNT_W-1:0] pos, logic fin);
      otl_pkg::out_item_t r;
      r.status   = st;
      r.slot_out = slot;
      r.tag_out  = tag;
      r.key_out  = key;
      r.position = pos;
      r.last     = fin;
      expected_q.push_back(r);
    endfunction

    function int rank_of(int unsigned slot);
      foreach (run_order[i]) if (run_order[i] == slot) return i;
      return -1;
    endfunction

    function void note_request(otl_pkg::in_item_t req);
      int unsigned slot;
      int          at;
      case (req.req_type)
        otl_pkg::REQ_INSERT: begin
          if (free_fifo.size() == 0) begin
            queue_result(otl_pkg::ST_POOL_FULL, '0, '0, '0,
                         otl_pkg::CNT_W'(run_order.size()), 1'b1);
          end else begin
            slot = free_fifo.pop_front();
            tag_of[slot] = req.task_tag;
            key_of[slot] = req.order_key;
            // new entry goes behind every entry with an equal or lower key
            at = 0;
            while (at < run_order.size() &&
                   $signed(key_of[run_order[at]]) <= $signed(req.order_key)) at++;
            run_order.insert(at, slot);
            queue_result(otl_pkg::ST_OK, otl_pkg::SLOT_W'(slot), req.task_tag,
                         req.order_key, otl_pkg::CNT_W'(run_order.size()), 1'b1);
          end
        end
        otl_pkg::REQ_REMOVE: begin
          slot = req.target_slot;
          at = rank_of(slot);
          if (at < 0) begin
            queue_result(otl_pkg::ST_NOT_LISTED, otl_pkg::SLOT_W'(slot), '0, '0,
                         otl_pkg::CNT_W'(run_order.size()), 1'b1);
          end else begin
            run_order.delete(at);
            free_fifo.push_back(slot);
            queue_result(otl_pkg::ST_OK, otl_pkg::SLOT_W'(slot), tag_of[slot],
                         key_of[slot], otl_pkg::CNT_W'(run_order.size()), 1'b1);
          end
        end
        otl_pkg::REQ_RETAG: begin
          slot = req.target_slot;
          if (rank_of(slot) < 0) begin
            queue_result(otl_pkg::ST_NOT_LISTED, otl_pkg::SLOT_W'(slot), '0, '0,
                         otl_pkg::CNT_W'(run_order.size()), 1'b1);
          end else begin
            tag_of[slot] = req.task_tag;
            queue_result(otl_pkg::ST_OK, otl_pkg::SLOT_W'(slot), req.task_tag,
                         key_of[slot], otl_pkg::CNT_W'(run_order.size()), 1'b1);
          end
        end
        default: begin
          if (run_order.size() == 0) begin
            queue_result(otl_pkg::ST_EMPTY, '0, '0, '0, '0, 1'b1);
          end else begin
            foreach (run_order[i]) begin
              slot = run_order[i];
              queue_result(otl_pkg::ST_OK, otl_pkg::SLOT_W'(slot), tag_of[slot],
                           key_of[slot], otl_pkg::CNT_W'(i + 1),
                           i + 1 == run_order.size());
            end
          end
        end
      endcase
    endfunction

    function void flag_field(string name, logic [31:0] want_v, logic [31:0] got_v);
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
    endfunction

    function void check_result(otl_pkg::out_item_t got);
      otl_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none, actual %p", $time, got);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) flag_field("status", want.status, got.status);
      if (got.slot_out !== want.slot_out) flag_field("slot_out", want.slot_out, got.slot_out);
      if (got.tag_out !== want.tag_out) flag_field("tag_out", want.tag_out, got.tag_out);
      if (got.key_out !== want.key_out) flag_field("key_out", want.key_out, got.key_out);
      if (got.position !== want.position) flag_field("position", want.position, got.position);
      if (got.last !== want.last) flag_field("last", want.last, got.last);
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  otl_pkg::in_item_t  in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  otl_pkg::out_item_t out_data_o;

  task_list_board board;
  bit          idle_on;
  int unsigned quiet_cycles;

  ordered_task_list uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // offers one request, waits for the transaction, then records it
  task automatic drive_request(otl_pkg::req_e kind,
                               logic signed [otl_pkg::KEY_BITS-1:0] key,
                               logic [otl_pkg::TAG_BITS-1:0] tag,
                               logic [otl_pkg::SLOT_W-1:0] slot);
    otl_pkg::in_item_t req;
    req.req_type    = kind;
    req.order_key   = key;
    req.task_tag    = tag;
    req.target_slot = slot;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    board.note_request(req);
  endtask

  // receiver side stalls in bursts
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(out_data_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int                                  roll;
    bit                                  filling;
    otl_pkg::req_e                       kind;
    logic signed [otl_pkg::KEY_BITS-1:0] key;
    logic [otl_pkg::SLOT_W-1:0]          slot;
    board        = new();
    idle_on      = 1'b1;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list and unlisted slots
    drive_request(otl_pkg::REQ_DISPATCH, 16'sh1234, 8'h5a, 3'd0);
    drive_request(otl_pkg::REQ_REMOVE, 16'sh0000, 8'h00, 3'd3);
    drive_request(otl_pkg::REQ_RETAG, 16'sh7fff, 8'hff, 3'd7);
    // fill all slots, key extremes and equal keys
    drive_request(otl_pkg::REQ_INSERT, 16'sh7fff, 8'hff, 3'd7);
    drive_request(otl_pkg::REQ_INSERT, 16'sh8000, 8'h00, 3'd0);
    drive_request(otl_pkg::REQ_INSERT, 16'sh0000, 8'haa, 3'd5);
    drive_request(otl_pkg::REQ_INSERT, 16'sh0000, 8'h55, 3'd2);
    drive_request(otl_pkg::REQ_INSERT, -16'sd1, 8'h0f, 3'd1);
    drive_request(otl_pkg::REQ_INSERT, 16'sh0001, 8'hf0, 3'd6);
    drive_request(otl_pkg::REQ_INSERT, 16'sh7fff, 8'h81, 3'd4);
    drive_request(otl_pkg::REQ_INSERT, 16'sh0000, 8'h7e, 3'd3);
    drive_request(otl_pkg::REQ_INSERT, 16'sh4321, 8'h11, 3'd0);
    drive_request(otl_pkg::REQ_DISPATCH, 16'sh0000, 8'h00, 3'd0);
    // retag, then head, tail and middle removal, then a repeat on a freed slot
    drive_request(otl_pkg::REQ_RETAG, 16'sh0000, 8'h3c, 3'd2);
    drive_request(otl_pkg::REQ_REMOVE, 16'sh0000, 8'h00, 3'd1);
    drive_request(otl_pkg::REQ_REMOVE, 16'sh0000, 8'h00, 3'd6);
    drive_request(otl_pkg::REQ_REMOVE, 16'sh0000, 8'h00, 3'd3);
    drive_request(otl_pkg::REQ_REMOVE, 16'sh0000, 8'h00, 3'd3);
    drive_request(otl_pkg::REQ_DISPATCH, 16'sh0000, 8'h00, 3'd0);
    drive_request(otl_pkg::REQ_INSERT, 16'sh0000, 8'hc3, 3'd0);
    drive_request(otl_pkg::REQ_INSERT, 16'sh8001, 8'h24, 3'd0);

    for (int n = 0; n < DIRECTED_ITEMS; n++) begin
      idle_on = (n < 70) && ((n / 15) % 3 != 2);
      // alternate phases that lean toward filling and toward draining
      filling = ((n / 20) % 2) == 0;
      roll = $urandom_range(0, 99);
      if (filling) begin
        kind = roll < 55 ? otl_pkg::REQ_INSERT : roll < 70 ? otl_pkg::REQ_REMOVE :
               roll < 85 ? otl_pkg::REQ_RETAG : otl_pkg::REQ_DISPATCH;
      end else begin
        kind = roll < 20 ? otl_pkg::REQ_INSERT : roll < 65 ? otl_pkg::REQ_REMOVE :
               roll < 80 ? otl_pkg::REQ_RETAG : otl_pkg::REQ_DISPATCH;
      end
      case ($urandom_range(0, 3))
        0: key = otl_pkg::KEY_BITS'($urandom_range(0, 4) - 2);
        1: begin
          case ($urandom_range(0, 3))
            0: key = 16'sh7fff;
            1: key = 16'sh8000;
            2: key = 16'sh0000;
            default: key = -16'sd1;
          endcase
        end
        default: key = otl_pkg::KEY_BITS'($urandom);
      endcase
      if (board.run_order.size() != 0 && $urandom_range(0, 3) != 0) begin
        slot = otl_pkg::SLOT_W'(board.run_order[$urandom_range(0, board.run_order.size() - 1)]);
      end else begin
        slot = otl_pkg::SLOT_W'($urandom_range(0, otl_pkg::SLOTS - 1));
      end
      drive_request(kind, key, otl_pkg::TAG_BITS'($urandom), slot);
    end
    in_valid_i <= 1'b0;

    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0 && board.expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/otl_pkg.sv
rtl/otl_cell.sv
rtl/ordered_task_list.sv
dv/tb.sv
